FILE: hdl/alte_pkg.sv
`default_nettype none
package alte_pkg;

  // input kind codes
  localparam logic [2:0] KIND_LOAD_W = 3'd0;
  localparam logic [2:0] KIND_LOAD_B = 3'd1;
  localparam logic [2:0] KIND_FWD    = 3'd2;
  localparam logic [2:0] KIND_GRAD   = 3'd3;
  localparam logic [2:0] KIND_UPD    = 3'd4;

  // wide enough for any supported layer size
  localparam int IDX_W = 6;
  localparam int ACC_W = 40;
  localparam int DW_W  = 40;
  localparam int DB_W  = 32;

  typedef enum logic [1:0] {
    OP_NONE = 2'd0,
    OP_FWD  = 2'd1,
    OP_GRAD = 2'd2,
    OP_UPD  = 2'd3
  } op_t;

  // token handed from cell to cell, one per step
  typedef struct packed {
    logic               vld;
    op_t                op;
    logic [IDX_W-1:0]   k;
    logic               bias;
    logic               last;
    logic               dx;
    logic [IDX_W-1:0]   sel;
    logic signed [15:0] x;
  } tok_t;

  // table writes taken at the input transfer
  typedef struct packed {
    logic               vld;
    logic [2:0]         kind;
    logic [IDX_W-1:0]   idx;
    logic [IDX_W-1:0]   col;
    logic signed [15:0] val;
    logic               clr;
  } cmd_t;

  // running input-gradient sum travelling along the row
  typedef struct packed {
    logic                   vld;
    logic [IDX_W-1:0]       k;
    logic                   last;
    logic signed [ACC_W-1:0] sum;
  } psum_t;

  // {clipped, value}
  function automatic logic [16:0] sat16(input logic signed [63:0] v);
    logic [16:0] r;
    if (v > 64'sd32767) begin
      r = {1'b1, 16'h7fff};
    end else if (v < -64'sd32768) begin
      r = {1'b1, 16'h8000};
    end else begin
      r = {1'b0, v[15:0]};
    end
    return r;
  endfunction

  function automatic logic signed [DW_W-1:0] sat40(input logic signed [63:0] v);
    logic signed [DW_W-1:0] r;
    if (v > 64'sd549755813887) begin
      r = {1'b0, {(DW_W-1){1'b1}}};
    end else if (v < -64'sd549755813888) begin
      r = {1'b1, {(DW_W-1){1'b0}}};
    end else begin
      r = v[DW_W-1:0];
    end
    return r;
  endfunction

  function automatic logic signed [DB_W-1:0] sat32(input logic signed [63:0] v);
    logic signed [DB_W-1:0] r;
    if (v > 64'sd2147483647) begin
      r = {1'b0, {(DB_W-1){1'b1}}};
    end else if (v < -64'sd2147483648) begin
      r = {1'b1, {(DB_W-1){1'b0}}};
    end else begin
      r = v[DB_W-1:0];
    end
    return r;
  endfunction

endpackage
`default_nettype wire

FILE: hdl/affine_layer_train_engine.sv
// Loads, non-final forward elements and unknown kinds start no run of their own.
// Row-ending forward elements, every gradient element and updates hold the input off
// for a run after their transfer (IN_SIZE token steps, IN_SIZE + 1 for updates, skew
// through OUT_SIZE cells, forward drain of OUT_SIZE results); results follow
// from a queue. Synchronous active-low reset: empties the queue, clears gradient sums,
// sets the learning rate to 655. Weight, bias and activation tables keep their contents.
`default_nettype none
module affine_layer_train_engine import alte_pkg::*; #(
  parameter int IN_SIZE   = 16,
  parameter int OUT_SIZE  = 16,
  parameter int MAX_BATCH = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [2:0]         in_kind,
  input  logic [5:0]         in_row,
  input  logic [3:0]         in_col,
  input  logic signed [15:0] in_value,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [3:0]         out_index,
  output logic signed [15:0] out_value,
  output logic               out_is_gradient,
  output logic               out_saturated,
  output logic               out_last,
  input  logic               cfg_wr_en,
  input  logic [15:0]        cfg_wr_data
);

  localparam int MAXR    = (IN_SIZE > OUT_SIZE) ? IN_SIZE : OUT_SIZE;
  localparam int FDEPTH  = 2 * MAXR;
  localparam int FCW     = $clog2(FDEPTH+1);
  localparam int SDEPTH  = MAX_BATCH * IN_SIZE;
  localparam int SW      = (SDEPTH > 1) ? $clog2(SDEPTH) : 1;
  localparam int RUN_LEN = IN_SIZE + 2*OUT_SIZE + 10;
  localparam int RW      = $clog2(RUN_LEN+1);
  localparam int KW      = $clog2(IN_SIZE+2);
  localparam int OW      = $clog2(OUT_SIZE+1);
  localparam int RES_W   = 23;

  typedef enum logic [1:0] {
    S_IDLE = 2'b01,
    S_RUN  = 2'b10
  } state_t;

  state_t            state_r, state_nxt;
  logic [15:0]       lr_r;
  logic signed [15:0] store [SDEPTH];

  logic              accept;
  logic              row_ok_b, col_ok_in, col_ok_out, w_ok;
  logic              fwd_ok, grad_ok, go;
  cmd_t              cmd;

  op_t               op_r;
  logic [5:0]        row_r;
  logic [IDX_W-1:0]  sel_r;
  logic              dx_r;
  logic [KW-1:0]     ntok_r, k_r;
  logic [RW-1:0]     run_r;
  logic              issue;
  tok_t              tk0_r;
  logic signed [15:0] x_rd_r;

  tok_t                    tk_w [OUT_SIZE+1];
  psum_t                   ps_w [OUT_SIZE+1];
  logic signed [ACC_W-1:0] y_w  [OUT_SIZE+1];

  logic              fd1_r, fd2_r, drain_r;
  logic [OW-1:0]     dr_idx_r;

  logic                    pr_vld_r, pr_grad_r, pr_last_r;
  logic [IDX_W-1:0]        pr_idx_r;
  logic signed [ACC_W-1:0] pr_acc_r;
  logic signed [63:0]      rnd;
  logic [16:0]             rs;
  logic [RES_W-1:0]        res_in, res_out;
  logic [FCW-1:0]          fifo_cnt;

  assign accept     = in_valid && in_ready;
  assign row_ok_b   = 32'(in_row) < MAX_BATCH;
  assign col_ok_in  = 32'(in_col) < IN_SIZE;
  assign col_ok_out = 32'(in_col) < OUT_SIZE;
  assign w_ok       = (32'(in_row) < IN_SIZE) && col_ok_out;
  assign fwd_ok     = (in_kind == KIND_FWD) && row_ok_b && col_ok_in;
  assign grad_ok    = (in_kind == KIND_GRAD) && row_ok_b && col_ok_out;
  assign go = accept && ((fwd_ok && 32'(in_col) == IN_SIZE-1) || grad_ok ||
                         in_kind == KIND_UPD);

  always_comb begin
    cmd      = '0;
    cmd.kind = in_kind;
    cmd.idx  = in_row;
    cmd.col  = IDX_W'(in_col);
    cmd.val  = in_value;
    cmd.clr  = grad_ok && in_row == '0 && in_col == '0;
    cmd.vld  = accept && (((in_kind == KIND_LOAD_W) && w_ok) ||
                          ((in_kind == KIND_LOAD_B) && col_ok_out) || grad_ok);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lr_r <= 16'd655;
    end else if (cfg_wr_en) begin
      lr_r <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (accept && fwd_ok) begin
      store[SW'(32'(in_row) * IN_SIZE + 32'(in_col))] <= in_value;
    end
    if (issue) begin
      x_rd_r <= store[SW'(32'(row_r) * IN_SIZE + 32'(k_r))];
    end
  end

  // step sequencer
  assign issue = (state_r == S_RUN) && (k_r < ntok_r);

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: if (go) state_nxt = S_RUN;
      S_RUN:  if (run_r == RW'(RUN_LEN-1)) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      run_r   <= '0;
      k_r     <= '0;
      ntok_r  <= '0;
      op_r    <= OP_NONE;
      tk0_r   <= '0;
    end else begin
      state_r <= state_nxt;
      if (go) begin
        run_r  <= '0;
        k_r    <= '0;
        ntok_r <= (in_kind == KIND_UPD) ? KW'(IN_SIZE+1) : KW'(IN_SIZE);
        op_r   <= (in_kind == KIND_UPD) ? OP_UPD :
                  (in_kind == KIND_FWD) ? OP_FWD : OP_GRAD;
      end else if (state_r == S_RUN) begin
        run_r <= run_r + RW'(1);
        if (issue) begin
          k_r <= k_r + KW'(1);
        end
      end
      tk0_r.vld  <= issue;
      tk0_r.op   <= op_r;
      tk0_r.bias <= (32'(k_r) == IN_SIZE);
      tk0_r.k    <= (32'(k_r) == IN_SIZE) ? '0 : IDX_W'(k_r);
      tk0_r.last <= (32'(k_r) == IN_SIZE-1);
      tk0_r.dx   <= dx_r;
      tk0_r.sel  <= sel_r;
      tk0_r.x    <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (go) begin
      row_r <= in_row;
      sel_r <= IDX_W'(in_col);
      dx_r  <= (32'(in_col) == OUT_SIZE-1);
    end
  end

  // cell row
  always_comb begin
    tk_w[0]   = tk0_r;
    tk_w[0].x = x_rd_r;
  end
  assign ps_w[0]       = '0;
  assign y_w[OUT_SIZE] = '0;

  for (genvar j = 0; j < OUT_SIZE; j++) begin : g_cell
    alte_cell #(
      .IN_SIZE (IN_SIZE),
      .J       (j)
    ) u_cell (
      .clk    (clk),
      .rst_n  (rst_n),
      .cmd    (cmd),
      .lr     (lr_r),
      .tk_in  (tk_w[j]),
      .tk_out (tk_w[j+1]),
      .ps_in  (ps_w[j]),
      .ps_out (ps_w[j+1]),
      .drain  (drain_r),
      .y_in   (y_w[j+1]),
      .y_out  (y_w[j])
    );
  end

  // forward results shift out through cell 0 once the far cell has finished
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fd1_r    <= 1'b0;
      fd2_r    <= 1'b0;
      drain_r  <= 1'b0;
      dr_idx_r <= '0;
    end else begin
      fd1_r <= tk_w[OUT_SIZE].vld && tk_w[OUT_SIZE].op == OP_FWD && tk_w[OUT_SIZE].last;
      fd2_r <= fd1_r;
      if (fd2_r) begin
        drain_r  <= 1'b1;
        dr_idx_r <= '0;
      end else if (drain_r) begin
        dr_idx_r <= dr_idx_r + OW'(1);
        if (32'(dr_idx_r) == OUT_SIZE-1) begin
          drain_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pr_vld_r <= 1'b0;
    end else begin
      pr_vld_r <= drain_r || ps_w[OUT_SIZE].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (drain_r) begin
      pr_acc_r  <= y_w[0];
      pr_idx_r  <= IDX_W'(dr_idx_r);
      pr_grad_r <= 1'b0;
      pr_last_r <= (32'(dr_idx_r) == OUT_SIZE-1);
    end else begin
      pr_acc_r  <= ps_w[OUT_SIZE].sum;
      pr_idx_r  <= ps_w[OUT_SIZE].k;
      pr_grad_r <= 1'b1;
      pr_last_r <= ps_w[OUT_SIZE].last;
    end
  end

  // round half up to Q8.8 and clip
  always_comb begin
    rnd    = (64'(pr_acc_r) + 64'sd128) >>> 8;
    rs     = sat16(rnd);
    res_in = {pr_idx_r[3:0], rs[15:0], pr_grad_r, rs[16], pr_last_r};
  end

  alte_fifo #(
    .DEPTH (FDEPTH),
    .W     (RES_W)
  ) u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (pr_vld_r),
    .push_data (res_in),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (res_out),
    .count     (fifo_cnt)
  );

  assign in_ready = (state_r == S_IDLE) && (32'(fifo_cnt) <= FDEPTH - MAXR);

  assign out_index       = res_out[22:19];
  assign out_value       = res_out[18:3];
  assign out_is_gradient = res_out[2];
  assign out_saturated   = res_out[1];
  assign out_last        = res_out[0];

`ifndef ASSERT_OFF
  a_tok_in_run: assert property (@(posedge clk) disable iff (!rst_n)
    tk_w[OUT_SIZE].vld |-> state_r == S_RUN)
    else $error("token left in cell row outside a run");
  a_no_mix: assert property (@(posedge clk) disable iff (!rst_n)
    !(drain_r && ps_w[OUT_SIZE].vld))
    else $error("forward drain and input gradient collide");
  a_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    pr_vld_r |-> 32'(fifo_cnt) < FDEPTH)
    else $error("result queue overflow");
`endif

endmodule
`default_nettype wire

FILE: hdl/alte_cell.sv
`default_nettype none
module alte_cell import alte_pkg::*; #(
  parameter int IN_SIZE = 16,
  parameter int J       = 0
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  cmd_t                    cmd,
  input  logic [15:0]             lr,
  input  tok_t                    tk_in,
  output tok_t                    tk_out,
  input  psum_t                   ps_in,
  output psum_t                   ps_out,
  input  logic                    drain,
  input  logic signed [ACC_W-1:0] y_in,
  output logic signed [ACC_W-1:0] y_out
);

  localparam int IW = (IN_SIZE > 1) ? $clog2(IN_SIZE) : 1;

  // column J of W and dW
  logic signed [15:0]     w_mem  [IN_SIZE];
  logic signed [DW_W-1:0] dw_mem [IN_SIZE];
  logic [IN_SIZE-1:0]     dw_vld_r;

  logic signed [15:0]     b_r;
  logic signed [15:0]     g_r;
  logic signed [DB_W-1:0] db_r;
  logic signed [ACC_W-1:0] y_r;

  tok_t                   tkb_r, tkc_r;
  logic signed [15:0]     w_rd_r;
  logic signed [DW_W-1:0] dw_rd_r;
  logic                   dwv_r;

  logic signed [31:0]     pa_r, pb_r;
  logic signed [41:0]     pl_r;
  logic signed [32:0]     ph_r;
  logic signed [15:0]     wc_r;
  logic signed [DW_W-1:0] dwc_r;
  psum_t                  ps_r;

  logic signed [15:0]     w_b, m_b;
  logic signed [DW_W-1:0] dw_b;
  logic signed [63:0]     full, dlt_w, dlt_b;
  logic [16:0]            w_sat, b_sat;
  logic signed [DW_W-1:0] dw_sum;
  logic signed [ACC_W-1:0] y_base;
  logic                   sel_me, cmd_me;

  assign sel_me = (tkc_r.sel == IDX_W'(J));
  assign cmd_me = (cmd.col == IDX_W'(J));

  // stage A: read the tables for this step
  always_ff @(posedge clk) begin
    if (tk_in.vld) begin
      w_rd_r  <= w_mem[tk_in.k[IW-1:0]];
      dw_rd_r <= dw_mem[tk_in.k[IW-1:0]];
      dwv_r   <= dw_vld_r[tk_in.k[IW-1:0]];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tkb_r <= '0;
      tkc_r <= '0;
    end else begin
      tkb_r <= tk_in;
      tkc_r <= tkb_r;
    end
  end

  // stage B: multiplies
  always_comb begin
    w_b  = tkb_r.bias ? b_r : w_rd_r;
    dw_b = tkb_r.bias ? DW_W'(db_r) : (dwv_r ? dw_rd_r : '0);
    m_b  = (tkb_r.op == OP_FWD) ? w_b : g_r;
  end

  always_ff @(posedge clk) begin
    pa_r  <= tkb_r.x * m_b;
    pb_r  <= g_r * w_b;
    pl_r  <= $signed({1'b0, dw_b[23:0]}) * $signed({1'b0, lr});
    ph_r  <= $signed(dw_b[39:24]) * $signed({1'b0, lr});
    wc_r  <= w_b;
    dwc_r <= dw_b;
  end

  // stage C: accumulate / write back
  always_comb begin
    full   = (64'(ph_r) <<< 24) + 64'(pl_r);
    dlt_w  = (full + 64'sd8388608) >>> 24;
    dlt_b  = (full + 64'sd32768) >>> 16;
    w_sat  = sat16(64'(wc_r) - dlt_w);
    b_sat  = sat16(64'(wc_r) - dlt_b);
    dw_sum = sat40(64'(dwc_r) + 64'(pa_r));
    y_base = (tkc_r.k == '0) ? (ACC_W'(b_r) <<< 8) : y_r;
  end

  always_ff @(posedge clk) begin
    if (cmd.vld && cmd.kind == KIND_LOAD_W && cmd_me) begin
      w_mem[cmd.idx[IW-1:0]] <= cmd.val;
    end else if (tkc_r.vld && tkc_r.op == OP_UPD && !tkc_r.bias) begin
      w_mem[tkc_r.k[IW-1:0]] <= w_sat[15:0];
    end
    if (tkc_r.vld && tkc_r.op == OP_GRAD && sel_me) begin
      dw_mem[tkc_r.k[IW-1:0]] <= dw_sum;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dw_vld_r <= '0;
    end else if (cmd.vld && cmd.clr) begin
      dw_vld_r <= '0;
    end else if (tkc_r.vld && tkc_r.op == OP_GRAD && sel_me) begin
      dw_vld_r[tkc_r.k[IW-1:0]] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      db_r <= '0;
    end else if (cmd.vld && cmd.kind == KIND_GRAD) begin
      if (cmd.clr) begin
        db_r <= cmd_me ? DB_W'(cmd.val) : '0;
      end else if (cmd_me) begin
        db_r <= sat32(64'(db_r) + 64'(cmd.val));
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.vld && cmd.kind == KIND_LOAD_B && cmd_me) begin
      b_r <= cmd.val;
    end else if (tkc_r.vld && tkc_r.op == OP_UPD && tkc_r.bias) begin
      b_r <= b_sat[15:0];
    end
    if (cmd.vld && cmd.kind == KIND_GRAD && cmd_me) begin
      g_r <= cmd.val;
    end
  end

  always_ff @(posedge clk) begin
    if (drain) begin
      y_r <= y_in;
    end else if (tkc_r.vld && tkc_r.op == OP_FWD) begin
      y_r <= y_base + ACC_W'(pa_r);
    end
  end

  // dx partial sum: one hop per cell, aligned with the token skew
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ps_r <= '0;
    end else begin
      ps_r.vld  <= tkc_r.vld && tkc_r.op == OP_GRAD && tkc_r.dx;
      ps_r.k    <= tkc_r.k;
      ps_r.last <= tkc_r.last;
      ps_r.sum  <= ps_in.sum + ACC_W'(pb_r);
    end
  end

  assign tk_out = tkb_r;
  assign ps_out = ps_r;
  assign y_out  = y_r;

endmodule
`default_nettype wire

FILE: hdl/alte_fifo.sv
`default_nettype none
module alte_fifo #(
  parameter int DEPTH = 32,
  parameter int W     = 23
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [W-1:0]                 push_data,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [W-1:0]                 out_data,
  output logic [$clog2(DEPTH+1)-1:0]   count
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH+1);

  logic [W-1:0]  mem [DEPTH];
  logic [AW-1:0] wp_r, rp_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ov_r;
  logic [W-1:0]  od_r;
  logic          pop;

  assign pop = (cnt_r != '0) && (!ov_r || out_ready);

  always_comb begin
    cnt_nxt = cnt_r;
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (!push && pop) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wp_r] <= push_data;
    end
    if (pop) begin
      od_r <= mem[rp_r];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      ov_r  <= 1'b0;
    end else begin
      cnt_r <= cnt_nxt;
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH-1)) ? '0 : wp_r + AW'(1);
      end
      if (pop) begin
        rp_r <= (rp_r == AW'(DEPTH-1)) ? '0 : rp_r + AW'(1);
        ov_r <= 1'b1;
      end else if (out_ready) begin
        ov_r <= 1'b0;
      end
    end
  end

  assign out_valid = ov_r;
  assign out_data  = od_r;
  assign count     = cnt_r + CW'(ov_r);

endmodule
`default_nettype wire

FILE: bench/tb.sv
`default_nettype none
module tb;
  import alte_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int NI = 16;
  localparam int NO = 16;
  localparam int NB = 64;
  localparam logic [2:0] KIND_RSV_FIRST = 3'd5;
  localparam logic [2:0] KIND_RSV_LAST  = 3'd7;
  localparam int SETTLE = 100;

  typedef struct {
    logic [3:0]         idx;
    logic signed [15:0] val;
    logic               grad;
    logic               sat;
    logic               last;
  } result_t;

  logic               clk;
  logic               rst_n;
  logic               in_valid;
  logic               in_ready;
  logic [2:0]         in_kind;
  logic [5:0]         in_row;
  logic [3:0]         in_col;
  logic signed [15:0] in_value;
  logic               out_valid;
  logic               out_ready;
  logic [3:0]         out_index;
  logic signed [15:0] out_value;
  logic               out_is_gradient;
  logic               out_saturated;
  logic               out_last;
  logic               cfg_wr_en;
  logic [15:0]        cfg_wr_data;

  affine_layer_train_engine i_dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_ready(in_ready), .in_kind(in_kind), .in_row(in_row),
    .in_col(in_col), .in_value(in_value),
    .out_valid(out_valid), .out_ready(out_ready), .out_index(out_index),
    .out_value(out_value), .out_is_gradient(out_is_gradient),
    .out_saturated(out_saturated), .out_last(out_last),
    .cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
  );

  // layer state as the engine should hold it
  longint      wt[NI*NO];
  longint      bs[NO];
  longint      act[NB*NI];
  longint      dwt[NI*NO];
  longint      dbs[NO];
  longint      drow[NO];
  logic [15:0] step_size;
  logic [15:0] row_filled[NB];

  result_t expected_q[$];
  bit      failed;
  bit      quiet;
  bit      long_hold_req;
  int      hold_cnt;
  int      stall_left;
  int      n_items;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #5ms;
    $display("tb failed");
    $finish;
  end

  function automatic longint clip(longint v, int bits, output bit c);
    longint hi, lo;
    hi = (longint'(1) <<< (bits - 1)) - 1;
    lo = -hi - 1;
    c = 1'b0;
    if (v > hi) begin
      c = 1'b1;
      return hi;
    end
    if (v < lo) begin
      c = 1'b1;
      return lo;
    end
    return v;
  endfunction

  function automatic void push_result(int idx, longint sum, bit grad, bit last);
    result_t r;
    bit c;
    longint y;
    y = clip((sum + 128) >>> 8, 16, c);
    r.idx  = idx[3:0];
    r.val  = y[15:0];
    r.grad = grad;
    r.sat  = c;
    r.last = last;
    expected_q.push_back(r);
  endfunction

  function automatic void layer_apply(logic [2:0] kind, int row, int col,
                                      logic signed [15:0] v);
    longint val, acc, delta;
    bit c;
    val = longint'(v);
    case (kind)
      KIND_LOAD_W: if (row < NI) wt[row*NO + col] = val;
      KIND_LOAD_B: bs[col] = val;
      KIND_FWD: begin
        act[row*NI + col] = val;
        row_filled[row][col] = 1'b1;
        if (col == NI - 1) begin
          for (int j = 0; j < NO; j++) begin
            acc = bs[j] * 256;
            for (int i = 0; i < NI; i++) acc += act[row*NI + i] * wt[i*NO + j];
            push_result(j, acc, 1'b0, j == NO - 1);
          end
        end
      end
      KIND_GRAD: begin
        if (row == 0 && col == 0) begin
          foreach (dwt[k]) dwt[k] = 0;
          foreach (dbs[k]) dbs[k] = 0;
        end
        drow[col] = val;
        for (int i = 0; i < NI; i++)
          dwt[i*NO + col] = clip(dwt[i*NO + col] + act[row*NI + i] * val, 40, c);
        dbs[col] = clip(dbs[col] + val, 32, c);
        if (col == NO - 1) begin
          for (int i = 0; i < NI; i++) begin
            acc = 0;
            for (int j = 0; j < NO; j++) acc += drow[j] * wt[i*NO + j];
            push_result(i, acc, 1'b1, i == NI - 1);
          end
        end
      end
      KIND_UPD: begin
        for (int k = 0; k < NI*NO; k++) begin
          delta = (dwt[k] * longint'(step_size) + (longint'(1) <<< 23)) >>> 24;
          wt[k] = clip(wt[k] - delta, 16, c);
        end
        for (int j = 0; j < NO; j++) begin
          delta = (dbs[j] * longint'(step_size) + (longint'(1) <<< 15)) >>> 16;
          bs[j] = clip(bs[j] - delta, 16, c);
        end
      end
      default: ;
    endcase
  endfunction

  // receiver: random short stalls, plus one long hold-off on request
  always @(posedge clk) begin
    if (long_hold_req) begin
      long_hold_req = 1'b0;
      hold_cnt = 300;
    end
    if (hold_cnt > 0) begin
      hold_cnt--;
      out_ready <= 1'b0;
    end else if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (!quiet && $urandom_range(0, 4) == 0) begin
      stall_left = $urandom_range(0, 2);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // result checker
  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (expected_q.size() == 0) begin
        $error("unexpected result: index %0d value %0d", out_index, out_value);
        failed = 1'b1;
      end else begin
        e = expected_q.pop_front();
        if (out_index !== e.idx) begin
          $error("out_index: expected %0d, got %0d", e.idx, out_index);
          failed = 1'b1;
        end
        if (out_value !== e.val) begin
          $error("out_value: expected %0d, got %0d", e.val, out_value);
          failed = 1'b1;
        end
        if (out_is_gradient !== e.grad) begin
          $error("out_is_gradient: expected %0b, got %0b", e.grad, out_is_gradient);
          failed = 1'b1;
        end
        if (out_saturated !== e.sat) begin
          $error("out_saturated: expected %0b, got %0b", e.sat, out_saturated);
          failed = 1'b1;
        end
        if (out_last !== e.last) begin
          $error("out_last: expected %0b, got %0b", e.last, out_last);
          failed = 1'b1;
        end
      end
    end
  end

  // leaves valid high after the transfer so back-to-back items need no re-raise
  task automatic send_item(logic [2:0] kind, logic [5:0] row, logic [3:0] col,
                           logic signed [15:0] v);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_kind  <= kind;
    in_row   <= row;
    in_col   <= col;
    in_value <= v;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    layer_apply(kind, row, col, v);
    n_items++;
  endtask

  task automatic wait_drained();
    in_valid <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_step_size(logic [15:0] lr);
    wait_drained();
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= lr;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    step_size = lr;
  endtask

  function automatic logic signed [15:0] rand_value();
    if ($urandom_range(0, 3) == 0) return $urandom_range(0, 65535);
    return $urandom_range(0, 1023) - 512;
  endfunction

  function automatic int pick_full_row();
    int r;
    do r = $urandom_range(0, NB - 1); while (row_filled[r] != 16'hffff);
    return r;
  endfunction

  task automatic fwd_row(int row, int upto);
    for (int c = 0; c <= upto; c++) send_item(KIND_FWD, row, c, rand_value());
  endtask

  task automatic grad_row_seq(int row, int upto);
    for (int c = 0; c <= upto; c++) send_item(KIND_GRAD, row, c, rand_value());
  endtask

  task automatic test_table_load();
    for (int i = 0; i < NI; i++)
      for (int j = 0; j < NO; j++)
        send_item(KIND_LOAD_W, i, j, $urandom_range(0, 255) - 128);
    for (int j = 0; j < NO; j++) send_item(KIND_LOAD_B, 0, j, $urandom_range(0, 511) - 256);
  endtask

  task automatic test_directed();
    // extremes of activation drive saturation both ways
    for (int c = 0; c < NI; c++) send_item(KIND_FWD, 0, c, 16'sh7fff);
    for (int c = 0; c < NI; c++) send_item(KIND_FWD, NB - 1, c, 16'sh8000);
    grad_row_seq(0, NO - 1);
    send_item(KIND_UPD, 0, 0, 16'sh0000);
    // ignored: weight index past the table, reserved kinds
    send_item(KIND_LOAD_W, 6'd63, 4'd15, 16'shffff);
    for (int k = KIND_RSV_FIRST; k <= KIND_RSV_LAST; k++)
      send_item(k[2:0], 6'h2a, 4'h5, 16'sh5a5a);
    fwd_row(0, NI - 1);
    grad_row_seq(NB - 1, NO - 1);
  endtask

  task automatic test_step_size();
    logic [15:0] setting[3];
    setting = '{16'd0, 16'hffff, 16'd4000};
    foreach (setting[s]) begin
      set_step_size(setting[s]);
      grad_row_seq(pick_full_row(), NO - 1);
      send_item(KIND_UPD, 0, 0, rand_value());
      fwd_row(pick_full_row(), NI - 1);
    end
  endtask

  task automatic test_backpressure();
    long_hold_req = 1'b1;
    for (int n = 0; n < 3; n++) fwd_row($urandom_range(0, NB - 1), NI - 1);
    wait_drained();
  endtask

  task automatic test_random(int goal);
    int r;
    while (n_items < goal) begin
      r = $urandom_range(0, 19);
      if (r < 8) begin
        fwd_row($urandom_range(0, NB - 1), (r == 0) ? $urandom_range(0, NI - 2) : NI - 1);
      end else if (r < 14) begin
        grad_row_seq((r == 8) ? 0 : pick_full_row(),
                     (r == 9) ? $urandom_range(0, NO - 2) : NO - 1);
      end else if (r < 15) begin
        send_item(KIND_UPD, $urandom_range(0, 63), $urandom_range(0, 15), rand_value());
      end else if (r < 17) begin
        send_item(KIND_LOAD_W, $urandom_range(0, NI - 1), $urandom_range(0, NO - 1),
                  $urandom_range(0, 255) - 128);
      end else if (r < 18) begin
        send_item(KIND_LOAD_B, $urandom_range(0, 63), $urandom_range(0, NO - 1),
                  $urandom_range(0, 511) - 256);
      end else if (r < 19) begin
        send_item(KIND_LOAD_W, $urandom_range(NI, 63), $urandom_range(0, 15), rand_value());
      end else begin
        send_item($urandom_range(KIND_RSV_FIRST, KIND_RSV_LAST), $urandom_range(0, 63),
                  $urandom_range(0, 15), rand_value());
      end
    end
  endtask

  initial begin
    rst_n       <= 1'b0;
    in_valid    <= 1'b0;
    in_kind     <= KIND_LOAD_W;
    in_row      <= '0;
    in_col      <= '0;
    in_value    <= '0;
    out_ready   <= 1'b0;
    cfg_wr_en   <= 1'b0;
    cfg_wr_data <= '0;
    step_size     = 16'd655;
    failed        = 1'b0;
    quiet         = 1'b0;
    long_hold_req = 1'b0;
    hold_cnt      = 0;
    stall_left    = 0;
    n_items       = 0;
    foreach (row_filled[r]) row_filled[r] = '0;
    foreach (dwt[k]) dwt[k] = 0;
    foreach (dbs[k]) dbs[k] = 0;
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_table_load();
    test_directed();
    test_step_size();
    test_backpressure();
    test_random(n_items + 40);
    set_step_size($urandom_range(1, 65534));
    quiet = 1'b1;
    test_random(n_items + 30);

    wait_drained();
    if (!failed) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end

endmodule
`default_nettype wire
